[src/swec_pkg.sv]
// Shared constants for the sliding window event counter.
// No dependencies; imported by sliding_window_event_counter, the checker and the testbench.
`default_nettype none

package swec_pkg;

    localparam int DEPTH_DEFAULT = 64;       // ring entries
    localparam int STAMP_W       = 32;       // timestamp width in ms
    localparam int WINDOW_W      = 16;       // window register width
    localparam int COUNT_W       = 7;        // event_count field width
    localparam int COUNT_MAX     = 127;      // event_count saturation value
    localparam int OUT_DATA_W    = 8;        // result tdata, byte padded

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd3000;

endpackage

`default_nettype wire

[src/sliding_window_event_counter.sv]
// Sliding window event counter: ring of recent timestamps in one synchronous RAM.
// Depends on swec_pkg for widths, reset value and the default depth.
//
// Each s_axis transaction carries a 32-bit event timestamp in ms. The block drops
// from the oldest end of the ring every stored stamp below (timestamp - window_ms),
// unless the timestamp is below the window, then appends the new stamp and returns
// one m_axis transaction with the ring occupancy (saturated at 127) and an overflow
// flag raised when the ring was full and its oldest entry had to be evicted. Each
// dropped entry costs one read-compare turn through the ring RAM, whose read data is
// registered, and each stored stamp is dropped at most once. Only one item is in
// flight; a new item is taken while the previous result still waits on m_axis. The
// window register is written over its own valid/ready channel (always ready) and must
// only change while the block is idle. No clearing pass is needed after reset: the
// ring is read only at entries the occupancy count marks as written.
`default_nettype none

module sliding_window_event_counter
    import swec_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration: window_ms
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [WINDOW_W-1:0]   i_cfg_data,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [STAMP_W-1:0]    s_axis_tdata,   // [31:0] timestamp
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [6:0] event_count, [7] zero pad
    output logic                       m_axis_tuser    // [0] overflow
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_FULL =
        COUNT_W'((DEPTH > COUNT_MAX) ? COUNT_MAX : DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,   // wait for a timestamp
        S_READ,   // ring RAM reads the oldest entry
        S_CMP,    // compare oldest entry against the lower edge
        S_FIN     // append, evict on full, hand result to the output register
    } t_state;

    t_state                r_state;
    logic [WINDOW_W-1:0]   r_window;
    logic [STAMP_W-1:0]    r_ts;
    logic [STAMP_W-1:0]    r_edge;
    logic                  r_chk;
    logic [PTR_W-1:0]      r_oldest;
    logic [PTR_W-1:0]      r_next;
    logic [OCC_W-1:0]      r_occ;
    logic                  r_out_valid;
    logic [COUNT_W-1:0]    r_count;
    logic                  r_ovf;

    // ring storage and its registered read port
    logic [STAMP_W-1:0]    r_ring [DEPTH];
    logic [STAMP_W-1:0]    r_rd_data;

    logic                  w_in_acc;
    logic                  w_slot_free;
    logic                  w_ring_wr;
    logic                  w_full;
    logic                  w_drop;
    logic [PTR_W-1:0]      w_oldest_inc;
    logic [PTR_W-1:0]      w_next_inc;
    logic [OCC_W-1:0]      w_occ_new;
    logic [COUNT_W-1:0]    w_count;
    logic [STAMP_W-1:0]    w_win_ext;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // the output register is free when empty or being drained this cycle
    assign w_slot_free = !r_out_valid || m_axis_tready;
    assign w_ring_wr   = (r_state == S_FIN) && w_slot_free;

    assign w_win_ext    = STAMP_W'(r_window);
    assign w_oldest_inc = (r_oldest == PTR_LAST) ? '0 : r_oldest + 1'b1;
    assign w_next_inc   = (r_next == PTR_LAST) ? '0 : r_next + 1'b1;
    assign w_full       = (r_occ >= OCC_FULL);

    // drop the oldest entry while it lies below the lower edge
    assign w_drop = r_chk && (r_occ != '0) && (r_rd_data < r_edge);

    // a full ring evicts one and appends one, so occupancy holds
    assign w_occ_new = w_full ? r_occ : r_occ + 1'b1;
    always_comb begin
        if (32'(w_occ_new) > COUNT_MAX) begin
            w_count = COUNT_W'(COUNT_MAX);
        end else begin
            w_count = COUNT_W'(w_occ_new);
        end
    end

    // ring RAM: one write port at next_ptr, one registered read at oldest_ptr
    always_ff @(posedge i_clk) begin
        if (w_ring_wr) begin
            r_ring[r_next] <= r_ts;
        end
        r_rd_data <= r_ring[r_oldest];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WINDOW_RESET;
            r_oldest    <= '0;
            r_next      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_cfg_data;
            end

            if (r_out_valid && m_axis_tready && !w_ring_wr) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_ts    <= s_axis_tdata;
                        r_edge  <= s_axis_tdata - w_win_ext;
                        r_chk   <= (s_axis_tdata >= w_win_ext);
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_drop) begin
                        r_oldest <= w_oldest_inc;
                        r_occ    <= r_occ - 1'b1;
                        r_state  <= S_READ;
                    end else begin
                        r_state  <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_slot_free) begin
                        if (w_full) begin
                            r_oldest <= w_oldest_inc;
                        end
                        r_next      <= w_next_inc;
                        r_occ       <= w_occ_new;
                        r_count     <= w_count;
                        r_ovf       <= w_full;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_count);
    assign m_axis_tuser  = r_ovf;

`ifndef ASSERT_OFF
    // occupancy never passes the ring depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_FULL)
        else $error("ring occupancy exceeds depth");

    // every result counts at least the new event
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[COUNT_W-1:0] != '0))
        else $error("result count is zero");

    // an eviction only happens on a full ring, so the count is the depth, capped at 127
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[COUNT_W-1:0] == COUNT_FULL))
        else $error("overflow raised on a ring that is not full");

    // an accepted item closes the input until its result is loaded
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item taken while one is in flight");
`endif

endmodule

`default_nettype wire

[tb/window_count_checker.sv]
// Checker for the sliding window event counter: follows the config, input and result
// channels, predicts every result and compares it field by field.
// Depends on swec_pkg for widths, the reset window and the default depth.
module window_count_checker
    import swec_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [WINDOW_W-1:0]   i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [STAMP_W-1:0]    i_in_data,    // [31:0] timestamp
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OUT_DATA_W-1:0] i_out_data,   // [6:0] event_count, [7] zero pad
    input  logic                  i_out_user,   // [0] overflow
    output int                    o_failures,
    output int                    o_pending,
    output int                    o_evictions
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } t_window_result;

    t_window_result      expected_results[$];
    logic [STAMP_W-1:0]  stamps[DEPTH];
    int                  oldest;
    int                  next_slot;
    int                  held;
    logic [WINDOW_W-1:0] window_len;
    int                  failures  = 0;
    int                  pending   = 0;
    int                  evictions = 0;

    assign o_failures  = failures;
    assign o_pending   = pending;
    assign o_evictions = evictions;

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        failures++;
    endtask

    // Drop stale stamps, evict on a full ring, append, and return the count.
    function automatic t_window_result count_in_window(input logic [STAMP_W-1:0] t);
        t_window_result     r;
        logic [STAMP_W-1:0] lower;
        r.overflow = 1'b0;
        if (t >= STAMP_W'(window_len)) begin
            lower = t - STAMP_W'(window_len);
            while (held > 0 && stamps[oldest] < lower) begin
                oldest = (oldest + 1) % DEPTH;
                held--;
            end
        end
        if (held >= DEPTH) begin
            oldest = (oldest + 1) % DEPTH;
            held--;
            r.overflow = 1'b1;
        end
        stamps[next_slot] = t;
        next_slot = (next_slot + 1) % DEPTH;
        held++;
        r.count = (held > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(held);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_window_result got;
        t_window_result want;
        if (!i_rst_n) begin
            oldest     = 0;
            next_slot  = 0;
            held       = 0;
            window_len = WINDOW_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                window_len = i_cfg_data;
            // Compare before pushing, so a result can never match its own input.
            if (i_out_valid && i_out_ready) begin
                got.count    = i_out_data[COUNT_W-1:0];
                got.overflow = i_out_user;
                if (expected_results.size() == 0) begin
                    flag_mismatch($sformatf("result count=%0d overflow=%0b with none pending",
                                            got.count, got.overflow));
                end else begin
                    want = expected_results.pop_front();
                    if (got.count != want.count)
                        flag_mismatch($sformatf("event_count %0d, expected %0d",
                                                got.count, want.count));
                    if (got.overflow != want.overflow)
                        flag_mismatch($sformatf("overflow %0b, expected %0b",
                                                got.overflow, want.overflow));
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = count_in_window(i_in_data);
                if (want.overflow)
                    evictions++;
                expected_results = {expected_results, want};
            end
        end
        pending = expected_results.size();
    end

endmodule

[tb/sliding_window_event_counter_tb.sv]
// Testbench top for the sliding window event counter: drives timestamps and window
// settings, throttles the result side and gives the verdict.
// Depends on swec_pkg, sliding_window_event_counter and window_count_checker.
module sliding_window_event_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swec_pkg::*;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [WINDOW_W-1:0]   i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [STAMP_W-1:0]    s_axis_tdata  = '0;   // [31:0] timestamp
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [6:0] event_count, [7] zero pad
    logic                  m_axis_tuser;         // [0] overflow

    int failures;
    int pending;
    int evictions;

    // Stimulus state shared with the result sink.
    bit                  calm           = 1'b0;   // no idling on either side
    int                  hold_req       = 0;      // bump to ask for a long hold-off
    int                  items_sent     = 0;
    int                  settings_used  = 0;
    logic [STAMP_W-1:0]  last_stamp     = '0;
    logic [WINDOW_W-1:0] window_now     = WINDOW_RESET;

    always #5 i_clk = ~i_clk;

    sliding_window_event_counter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    window_count_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .o_failures  (failures),
        .o_pending   (pending),
        .o_evictions (evictions)
    );

    // Result sink: drop ready about 9 percent of the time, or hold it low for a long
    // stretch on request so the block fills up and stalls its input.
    initial begin : result_sink
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 9);
        end
    end

    // Offer one timestamp and return at the falling edge after its transaction,
    // with valid still high so back-to-back items need no extra assignment.
    task automatic push_stamp(input logic [STAMP_W-1:0] t);
        if (!calm && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        last_stamp = t;
        items_sent++;
    endtask

    // Lower valid and hold until every predicted result has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // Write the window register; only while the block is idle.
    task automatic set_window(input logic [WINDOW_W-1:0] w);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        window_now = w;
        settings_used++;
    endtask

    // Mostly increasing stamps with steps sized against the window, plus big jumps,
    // repeats and steps backward. A burst phase steps by one to fill the ring.
    task automatic run_phase(input int n_items);
        int                 scale;
        int                 pick;
        bit                 burst;
        logic [STAMP_W-1:0] t;
        scale = int'(window_now) / $urandom_range(1, 64) + 1;
        burst = ($urandom_range(9) == 0);
        if ($urandom_range(4) == 0)
            last_stamp = $urandom();
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (burst)
                t = last_stamp + 1;
            else if (pick < 80)
                t = last_stamp + $urandom_range(1, 2 * scale);
            else if (pick < 88)
                t = last_stamp + $urandom_range(1, 4 * int'(window_now) + 2);
            else if (pick < 93)
                t = last_stamp + $urandom_range(1, 32'h7FFF_FFFF);
            else if (pick < 97)
                t = last_stamp;
            else
                t = last_stamp - $urandom_range(0, scale);
            push_stamp(t);
        end
    endtask

    initial begin : stimulus
        int phase;
        phase = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window: stamps below the window, the inclusive lower edge, a big
        // drop, the top of the range and a step backward.
        push_stamp(32'd0);
        push_stamp(32'd1);
        push_stamp(32'd2999);
        push_stamp(32'd3000);
        push_stamp(32'd3001);
        push_stamp(32'd3002);
        push_stamp(32'd6002);
        push_stamp(32'd6003);
        push_stamp(32'h7FFF_FFFF);
        push_stamp(32'hFFFF_FFFF);
        push_stamp(32'd5);
        push_stamp(32'd3006);
        // Zero window: equal stamps stay, earlier ones go.
        set_window('0);
        push_stamp(32'd100);
        push_stamp(32'd100);
        push_stamp(32'd101);
        push_stamp(32'd101);
        push_stamp(32'd50);
        // Widest window.
        set_window('1);
        push_stamp(32'd10);
        push_stamp(32'd65535);
        push_stamp(32'd65546);
        push_stamp(32'd200000);

        while (items_sent < 1200) begin
            phase++;
            case ($urandom_range(5))
                0: set_window('0);
                1: set_window('1);
                2: set_window(WINDOW_W'($urandom_range(1, 50)));
                3: set_window(WINDOW_W'($urandom_range(51, 5000)));
                4: set_window(WINDOW_W'($urandom()));
                default: set_window(WINDOW_RESET);
            endcase
            calm = (phase == 3);
            if (phase == 2)
                hold_req++;
            run_phase($urandom_range(40, 120));
        end
        calm = 1'b0;

        wait_drained();
        repeat (200) @(negedge i_clk);
        $display("summary: %0d timestamps over %0d window settings, %0d full-ring evictions",
                 items_sent, settings_used, evictions);
        if (failures == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[sliding_window_event_counter.f]
src/swec_pkg.sv
src/sliding_window_event_counter.sv
tb/window_count_checker.sv
tb/sliding_window_event_counter_tb.sv
